@@ hw/rtl/salc_pkg.sv @@
// Shared types, constants and defaults for the set-associative LRU cache tag block.
// Used by salc_cfg, salc_way_logic and the top module; depends on nothing.
package salc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_W_DEF       = 64;

  localparam int OFFSET_MAX = 32;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // Clamped configuration as the datapath uses it.
  typedef struct packed {
    logic [3:0] set_w;
    logic [5:0] off_bits;
    logic [4:0] ways;
  } cfg_t;

endpackage

@@ hw/rtl/salc_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/salc_cfg.sv @@
// APB-style configuration registers with clamping of the values to their legal ranges.
// Depends on salc_pkg.
module salc_cfg #(
  parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [salc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [salc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [salc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output salc_pkg::cfg_t               cfg
);
  import salc_pkg::*;

  logic [2:0] set_w_r;
  logic [5:0] off_bits_r;
  logic [3:0] ways_r;
  logic       wr_en;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_w_r    <= 3'd1;
      off_bits_r <= 6'd1;
      ways_r     <= 4'd1;
    end else if (wr_en) begin
      case (idx)
        REG_SET_BITS: set_w_r    <= cfg_pwdata[2:0];
        REG_OFF_BITS: off_bits_r <= cfg_pwdata[5:0];
        REG_WAYS:     ways_r     <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SET_BITS: cfg_prdata = CFG_DW'(set_w_r);
      REG_OFF_BITS: cfg_prdata = CFG_DW'(off_bits_r);
      REG_WAYS:     cfg_prdata = CFG_DW'(ways_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // A zero value acts as one; values above the maximum saturate.
  always_comb begin
    if (set_w_r == 3'd0) cfg.set_w = 4'd1;
    else if (32'(set_w_r) > MAX_SET_BITS) cfg.set_w = 4'(MAX_SET_BITS);
    else cfg.set_w = 4'(set_w_r);

    if (off_bits_r == 6'd0) cfg.off_bits = 6'd1;
    else if (32'(off_bits_r) > OFFSET_MAX) cfg.off_bits = 6'(OFFSET_MAX);
    else cfg.off_bits = off_bits_r;

    if (ways_r == 4'd0) cfg.ways = 5'd1;
    else if (32'(ways_r) > MAX_WAYS) cfg.ways = 5'(MAX_WAYS);
    else cfg.ways = 5'(ways_r);
  end

endmodule

@@ hw/rtl/salc_way_logic.sv @@
// Per-set lookup: scans the ways for an empty line or a tag match, picks the LRU victim
// and produces the updated row of valid bits, tags and age ranks. Depends on salc_pkg.
module salc_way_logic #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
  parameter int TAG_W    = salc_pkg::ADDR_W_DEF - 2,
  parameter int REC_W    = 3
) (
  input  logic [MAX_WAYS-1:0]             valid_in,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_in,
  input  logic [MAX_WAYS-1:0][REC_W-1:0]  rec_in,
  input  logic [TAG_W-1:0]                tag,
  input  logic [4:0]                      ways,
  output logic [1:0]                      outcome,
  output logic [MAX_WAYS-1:0]             valid_out,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_out,
  output logic [MAX_WAYS-1:0][REC_W-1:0]  rec_out
);
  import salc_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic             found;
  logic [WAY_W-1:0] target;
  logic             was_valid;
  logic [REC_W-1:0] old_rec;

  always_comb begin
    found   = 1'b0;
    outcome = OUT_EVICT;
    target  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(ways) && !found) begin
        if (!valid_in[w]) begin
          outcome = OUT_MISS;
          target  = WAY_W'(w);
          found   = 1'b1;
        end else if (tag_in[w] == tag) begin
          outcome = OUT_HIT;
          target  = WAY_W'(w);
          found   = 1'b1;
        end else if (rec_in[w] > rec_in[target]) begin
          target = WAY_W'(w);
        end
      end
    end
  end

  assign was_valid = valid_in[target];
  assign old_rec   = rec_in[target];

  // Lines younger than the touched one age by one; on a fill every valid line ages.
  always_comb begin
    valid_out = valid_in;
    tag_out   = tag_in;
    rec_out   = rec_in;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == target) begin
        rec_out[w] = '0;
        if (outcome != OUT_HIT) begin
          valid_out[w] = 1'b1;
          tag_out[w]   = tag;
        end
      end else if (valid_in[w] && (!was_valid || rec_in[w] < old_rec)) begin
        rec_out[w] = rec_in[w] + REC_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/set_assoc_lru_cache_tags_top.sv @@
// Set-associative cache tag block with LRU replacement: one result per access. An accepted
// access issues the set memory read; the lookup state then updates and writes back the row.
// A result held by a stalled output delays the write-back, and no new access is taken before
// it. After reset a clearing pass invalidates all 2^MAX_SET_BITS sets (64 by default), during
// which no transfer is accepted. Depends on salc_pkg, salc_cfg, salc_ram and salc_way_logic.
module set_assoc_lru_cache_tags_top #(
  parameter int MAX_SET_BITS  = salc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS      = salc_pkg::MAX_WAYS_DEF,
  parameter int ADDRESS_WIDTH = salc_pkg::ADDR_W_DEF,
  localparam int IN_DW        = ((ADDRESS_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_DW-1:0]             in_tdata,   // address
  input  logic [1:0]                   in_tuser,   // operation
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // set_index[5:0], offset[37:6], hit_total[69:38], miss_total[101:70],
  // eviction_total[133:102], zero pad
  output logic [135:0]                 out_tdata,
  output logic [2:0]                   out_tuser,  // outcome[1:0], second_hit[2]
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [salc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [salc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [salc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import salc_pkg::*;

  localparam int SETW  = MAX_SET_BITS;
  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int TAG_W = ADDRESS_WIDTH - 2;
  localparam int REC_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ROW_W = MAX_WAYS * (1 + TAG_W + REC_W);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  cfg_t cfg;

  logic [1:0]        state_r, state_nxt;
  logic [SETW-1:0]   clr_r, clr_nxt;
  logic [SETW-1:0]   set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [31:0]       off_r;
  logic [1:0]        op_r;
  logic [31:0]       hits_r, misses_r, evicts_r;
  logic              out_valid_r;
  logic [1:0]        out_outcome_r;
  logic              out_second_r;
  logic [SETW-1:0]   out_set_r;
  logic [31:0]       out_off_r;

  logic [ADDRESS_WIDTH-1:0] addr;
  logic                     in_fire, look_done;
  logic [6:0]               tag_shift;

  logic [ROW_W-1:0]                      rd_row, wr_row;
  logic                                  ram_we;
  logic [SETW-1:0]                       ram_waddr;
  logic [ROW_W-1:0]                      ram_wdata;
  logic [MAX_WAYS-1:0]                   v_in, v_out;
  logic [MAX_WAYS-1:0][TAG_W-1:0]        t_in, t_out;
  logic [MAX_WAYS-1:0][REC_W-1:0]        r_in, r_out;
  logic [1:0]                            outcome;
  logic                                  modify;
  logic [31:0]                           hits_a, hits_b, misses_n, evicts_n;

  salc_cfg #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign look_done = (state_r == ST_LOOK) && (!out_valid_r || out_tready);
  assign addr      = in_tdata[ADDRESS_WIDTH-1:0];
  assign tag_shift = 7'(cfg.off_bits) + 7'(cfg.set_w);

  // Address split registered at acceptance; the memory read decodes the set from the raw address.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      off_r <= 32'(addr & ((ADDRESS_WIDTH'(1) << cfg.off_bits) - ADDRESS_WIDTH'(1)));
      set_r <= SETW'((addr >> cfg.off_bits)
                     & ADDRESS_WIDTH'((SETW + 1)'((SETW + 1)'(1) << cfg.set_w)
                                      - (SETW + 1)'(1)));
      tag_r <= TAG_W'(addr >> tag_shift);
      op_r  <= in_tuser;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + SETW'(1);
        if (clr_r == SETW'(NSETS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE:  if (in_fire) state_nxt = ST_LOOK;
      ST_LOOK:  if (look_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) || look_done;
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : set_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : wr_row;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (SETW'((addr >> cfg.off_bits)
                  & ADDRESS_WIDTH'((SETW + 1)'((SETW + 1)'(1) << cfg.set_w)
                                   - (SETW + 1)'(1)))),
    .rdata (rd_row)
  );

  assign v_in   = rd_row[ROW_W-1 -: MAX_WAYS];
  assign t_in   = rd_row[MAX_WAYS*REC_W +: MAX_WAYS*TAG_W];
  assign r_in   = rd_row[0 +: MAX_WAYS*REC_W];
  assign wr_row = {v_out, t_out, r_out};

  salc_way_logic #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .REC_W    (REC_W)
  ) u_ways (
    .valid_in  (v_in),
    .tag_in    (t_in),
    .rec_in    (r_in),
    .tag       (tag_r),
    .ways      (cfg.ways),
    .outcome   (outcome),
    .valid_out (v_out),
    .tag_out   (t_out),
    .rec_out   (r_out)
  );

  // Saturating totals; a modify adds a second hit on top of its lookup.
  assign modify   = (op_r == OP_MODIFY);
  assign hits_a   = ((outcome == OUT_HIT) && hits_r != '1) ? hits_r + 32'd1 : hits_r;
  assign hits_b   = (modify && hits_a != '1) ? hits_a + 32'd1 : hits_a;
  assign misses_n = ((outcome != OUT_HIT) && misses_r != '1) ? misses_r + 32'd1 : misses_r;
  assign evicts_n = ((outcome == OUT_EVICT) && evicts_r != '1) ? evicts_r + 32'd1 : evicts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (look_done) begin
        hits_r      <= hits_b;
        misses_r    <= misses_n;
        evicts_r    <= evicts_n;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_done) begin
      out_outcome_r <= outcome;
      out_second_r  <= modify;
      out_set_r     <= set_r;
      out_off_r     <= off_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_second_r, out_outcome_r};
  assign out_tdata  = {2'b00, evicts_r, misses_r, hits_r, out_off_r, 6'(out_set_r)};

endmodule
